/* design/rv32i_instruction_execute_assert.svh */
// Assertion macros for the RV32I execute block.
`ifndef RV32I_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RV32I_INSTRUCTION_EXECUTE_ASSERT_SVH
`ifndef SYNTHESIS
`define RVX_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RVX_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RVX_ASSERT_IMP(name, ante, cons, msg)
`define RVX_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

/* design/rvx_pkg.sv */
// Shared types and encodings for the RV32I execute block.
package rvx_pkg;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_SW = 3'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;
    localparam logic [1:0] ST_MISAL = 2'd3;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd1;
    localparam logic [2:0] ALU_XOR = 3'd2;
    localparam logic [2:0] ALU_OR  = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;

    typedef struct packed {
        logic       load;
        logic [2:0] op;
        logic       shift_en;
        logic       shift_left;
        logic       shift_arith;
        logic [4:0] shamt;
    } alu_ctrl_t;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] ash;
        logic        carry;
        logic        ne;
        logic        a_msb;
        logic        b_msb;
    } alu_res_t;

endpackage

/* design/rv32i_instruction_execute.sv */
// RV32I execute block, top level: control, register file and result beat.
// ALU, jump and branch beats run on the bit-serial adder lanes, shifts then on the
// one-place shifter; loads and stores add the bit-serial address reduction and a
// memory pass per byte; a preload uses the address reduction only. One beat at a time;
// busy covers the whole beat. After reset the data memory is cleared, one word a cycle.
// Each result shows for one cycle with done; the receiver cannot stall.
`include "rv32i_instruction_execute_assert.svh"
module rv32i_instruction_execute import rvx_pkg::*;
#(
    parameter int          DATA_MEM_WORDS = 16384,
    parameter logic [31:0] STACK_RESET    = 32'd65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] instr_word,
    input  logic [13:0] preload_index,
    input  logic [31:0] preload_word,
    output logic        done,
    output logic [31:0] pc_after,
    output logic [4:0]  dest_reg,
    output logic [31:0] dest_value,
    output logic        dest_written,
    output logic [1:0]  status
);

    localparam int BW = $clog2(DATA_MEM_WORDS * 4);
    localparam int AW = $clog2(DATA_MEM_WORDS);
    localparam logic [BW-1:0] BA_LAST  = BW'(DATA_MEM_WORDS * 4 - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(DATA_MEM_WORDS - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RFRD  = 4'd2;
    localparam logic [3:0] S_ALU   = 4'd3;
    localparam logic [3:0] S_MOD   = 4'd4;
    localparam logic [3:0] S_MRD   = 4'd5;
    localparam logic [3:0] S_MRDW  = 4'd6;
    localparam logic [3:0] S_PRE   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic          req_reg;
    logic [31:0]   instr_reg, pword_reg, pc_reg;
    logic [31:0]   rf_valid_reg;
    logic [31:0]   rf_rd1_reg, rf_rd2_reg;
    logic          v1_reg, v2_reg;
    logic [BW-1:0] ba_reg;
    logic [1:0]    byte_reg;
    logic [31:0]   ld_reg;

    logic          done_reg, dw_reg;
    logic [31:0]   pc_out_reg, dv_reg;
    logic [4:0]    dr_reg;
    logic [1:0]    st_reg;

    logic [31:0]   rf_mem [32];

    logic          accept;
    logic [6:0]    opc, f7;
    logic [2:0]    f3;
    logic [4:0]    rd, rs1, rs2;
    logic [31:0]   imm_i, imm_s, imm_b, imm_u, imm_j;
    logic          is_zero, unsup, is_load, is_store;
    logic [31:0]   a_val, b_val;

    alu_ctrl_t     alu_ctrl;
    alu_res_t      alu_res;
    logic          alu_done;
    logic [31:0]   alu_a, alu_b, alu_c;

    logic          mod_start, mod_sel, mod_done;
    logic [31:0]   mod_value;
    logic [BW-1:0] mod_rem;

    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata, mem_rdata;
    logic [4:0]    bsh;
    logic [7:0]    sbyte, rbyte;
    logic [31:0]   ld_next, merged, ld_ext;
    logic [1:0]    byte_last;
    logic [BW-1:0] ba_next;

    logic          lt_s, take, wr, misal, commit;
    logic [31:0]   npc, res_val;
    logic [1:0]    fin_status;

    function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
        return (idx == 5'd2) ? STACK_RESET : 32'd0;
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // decode
    always_comb
    begin
        opc   = instr_reg[6:0];
        rd    = instr_reg[11:7];
        f3    = instr_reg[14:12];
        rs1   = instr_reg[19:15];
        rs2   = instr_reg[24:20];
        f7    = instr_reg[31:25];
        imm_i = {{20{instr_reg[31]}}, instr_reg[31:20]};
        imm_s = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
        imm_b = {{19{instr_reg[31]}}, instr_reg[31], instr_reg[7], instr_reg[30:25],
                 instr_reg[11:8], 1'b0};
        imm_u = {instr_reg[31:12], 12'd0};
        imm_j = {{11{instr_reg[31]}}, instr_reg[31], instr_reg[19:12], instr_reg[20],
                 instr_reg[30:21], 1'b0};
        is_zero  = (instr_reg == 32'd0);
        is_load  = (opc == OPC_LOAD);
        is_store = (opc == OPC_STORE);
        case (opc)
            OPC_OP:
                unsup = !((f7 == F7_BASE) ||
                          ((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR))));
            OPC_OPIMM:
                unsup = ((f3 == F3_SLL) && (f7 != F7_BASE)) ||
                        ((f3 == F3_SR) && (f7 != F7_BASE) && (f7 != F7_ALT));
            OPC_LOAD:   unsup = !(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU});
            OPC_STORE:  unsup = !(f3 inside {F3_SB, F3_SH, F3_SW});
            OPC_LUI:    unsup = 1'b0;
            OPC_AUIPC:  unsup = 1'b0;
            OPC_JAL:    unsup = 1'b0;
            OPC_JALR:   unsup = (f3 != 3'd0);
            OPC_BRANCH:
                unsup = !(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU});
            default:    unsup = 1'b1;
        endcase
        a_val = v1_reg ? rf_rd1_reg : rf_reset_value(rs1);
        b_val = v2_reg ? rf_rd2_reg : rf_reset_value(rs2);
    end

    // ALU operand setup
    always_comb
    begin
        alu_ctrl.load        = (state_reg == S_RFRD) && !is_zero && !unsup;
        alu_ctrl.op          = ALU_ADD;
        alu_ctrl.shift_en    = 1'b0;
        alu_ctrl.shift_left  = (f3 == F3_SLL);
        alu_ctrl.shift_arith = f7[5];
        alu_ctrl.shamt       = instr_reg[24:20];
        alu_a = a_val;
        alu_b = imm_i;
        alu_c = 32'd0;
        case (opc)
            OPC_OP, OPC_OPIMM:
            begin
                if (opc == OPC_OP)
                begin
                    alu_b          = b_val;
                    alu_ctrl.shamt = b_val[4:0];
                end
                alu_ctrl.shift_en = (f3 == F3_SLL) || (f3 == F3_SR);
                case (f3)
                    F3_ADD:  alu_ctrl.op = ((opc == OPC_OP) && f7[5]) ? ALU_SUB : ALU_ADD;
                    F3_SLT:  alu_ctrl.op = ALU_SUB;
                    F3_SLTU: alu_ctrl.op = ALU_SUB;
                    F3_XOR:  alu_ctrl.op = ALU_XOR;
                    F3_OR:   alu_ctrl.op = ALU_OR;
                    F3_AND:  alu_ctrl.op = ALU_AND;
                    default: alu_ctrl.op = ALU_ADD;
                endcase
            end
            OPC_STORE:  alu_b = imm_s;
            OPC_LUI:
            begin
                alu_a = 32'd0;
                alu_b = imm_u;
            end
            OPC_AUIPC:  alu_c = imm_u;
            OPC_JAL:    alu_c = imm_j;
            OPC_BRANCH:
            begin
                alu_b       = b_val;
                alu_ctrl.op = ALU_SUB;
                alu_c       = imm_b;
            end
            default:    alu_c = 32'd0;
        endcase
    end

    rvx_serial_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (alu_ctrl),
        .opa   (alu_a),
        .opb   (alu_b),
        .opp   (pc_reg),
        .opc   (alu_c),
        .res   (alu_res),
        .done  (alu_done)
    );

    assign mod_start = (accept && req_type) ||
                       ((state_reg == S_ALU) && alu_done && (is_load || is_store));
    assign mod_sel   = (state_reg == S_IDLE);
    assign mod_value = mod_sel ? {18'd0, preload_index} : alu_res.rx;

    rvx_mod_unit #(.DATA_MEM_WORDS(DATA_MEM_WORDS)) u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .sel_words (mod_sel),
        .value     (mod_value),
        .rem       (mod_rem),
        .done      (mod_done)
    );

    // byte lane handling
    always_comb
    begin
        bsh     = {ba_reg[1:0], 3'd0};
        sbyte   = 8'(b_val >> {byte_reg, 3'd0});
        rbyte   = 8'(mem_rdata >> bsh);
        ld_next = ld_reg | ({24'd0, rbyte} << {byte_reg, 3'd0});
        merged  = (mem_rdata & ~(32'hFF << bsh)) | ({24'd0, sbyte} << bsh);
        case (f3[1:0])
            2'd0:    byte_last = 2'd0;
            2'd1:    byte_last = 2'd1;
            default: byte_last = 2'd3;
        endcase
        ba_next = (ba_reg == BA_LAST) ? '0 : ba_reg + 1'b1;
    end

    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = ba_reg[BW-1:2];
        mem_wdata = merged;
        case (state_reg)
            S_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 32'd0;
            end
            S_PRE:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = ba_reg[AW-1:0];
                mem_wdata = pword_reg;
            end
            S_MRD:   mem_en = 1'b1;
            S_MRDW:
            begin
                mem_en = is_store;
                mem_we = is_store;
            end
            default: mem_en = 1'b0;
        endcase
    end

    rvx_data_mem #(.DATA_MEM_WORDS(DATA_MEM_WORDS)) u_mem
    (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // writeback
    always_comb
    begin
        lt_s = (alu_res.a_msb != alu_res.b_msb) ? alu_res.a_msb : !alu_res.carry;
        case (f3)
            F3_BEQ:  take = !alu_res.ne;
            F3_BNE:  take = alu_res.ne;
            F3_BLT:  take = lt_s;
            F3_BGE:  take = !lt_s;
            F3_BLTU: take = !alu_res.carry;
            F3_BGEU: take = alu_res.carry;
            default: take = 1'b0;
        endcase
        case (f3)
            F3_LB:   ld_ext = {{24{ld_reg[7]}}, ld_reg[7:0]};
            F3_LH:   ld_ext = {{16{ld_reg[15]}}, ld_reg[15:0]};
            F3_LBU:  ld_ext = {24'd0, ld_reg[7:0]};
            F3_LHU:  ld_ext = {16'd0, ld_reg[15:0]};
            default: ld_ext = ld_reg;
        endcase
        npc     = alu_res.rz;
        res_val = 32'd0;
        wr      = 1'b0;
        misal   = 1'b0;
        case (opc)
            OPC_OP, OPC_OPIMM:
            begin
                wr = 1'b1;
                case (f3)
                    F3_SLL, F3_SR: res_val = alu_res.ash;
                    F3_SLT:        res_val = {31'd0, lt_s};
                    F3_SLTU:       res_val = {31'd0, !alu_res.carry};
                    default:       res_val = alu_res.rx;
                endcase
            end
            OPC_LOAD:
            begin
                wr      = 1'b1;
                res_val = ld_ext;
            end
            OPC_LUI:
            begin
                wr      = 1'b1;
                res_val = alu_res.rx;
            end
            OPC_AUIPC:
            begin
                wr      = 1'b1;
                res_val = alu_res.ry;
            end
            OPC_JAL:
            begin
                wr      = 1'b1;
                res_val = alu_res.rz;
                npc     = alu_res.ry;
                misal   = (alu_res.ry[1:0] != 2'd0);
            end
            OPC_JALR:
            begin
                wr      = 1'b1;
                res_val = alu_res.rz;
                npc     = {alu_res.rx[31:1], 1'b0};
                misal   = alu_res.rx[1];
            end
            OPC_BRANCH:
            begin
                npc   = take ? alu_res.ry : alu_res.rz;
                misal = take && (alu_res.ry[1:0] != 2'd0);
            end
            default: wr = 1'b0;
        endcase
        if (req_reg)
            fin_status = ST_OK;
        else if (is_zero)
            fin_status = ST_HALT;
        else if (unsup)
            fin_status = ST_UNSUP;
        else if (misal)
            fin_status = ST_MISAL;
        else
            fin_status = ST_OK;
        commit = (state_reg == S_FIN) && !req_reg && (fin_status == ST_OK);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = req_type ? S_MOD : S_RFRD;
            S_RFRD:  state_next = (is_zero || unsup) ? S_FIN : S_ALU;
            S_ALU:
                if (alu_done)
                    state_next = (is_load || is_store) ? S_MOD : S_FIN;
            S_MOD:   if (mod_done) state_next = req_reg ? S_PRE : S_MRD;
            S_MRD:   state_next = S_MRDW;
            S_MRDW:  state_next = (byte_reg == byte_last) ? S_FIN : S_MRD;
            S_PRE:   state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            rf_valid_reg <= 32'd0;
            pc_reg       <= 32'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (commit)
                pc_reg <= npc;
            if (commit && wr && (rd != 5'd0))
                rf_valid_reg[rd] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            instr_reg  <= instr_word;
            pword_reg  <= preload_word;
            rf_rd1_reg <= rf_mem[instr_word[19:15]];
            rf_rd2_reg <= rf_mem[instr_word[24:20]];
            v1_reg     <= rf_valid_reg[instr_word[19:15]];
            v2_reg     <= rf_valid_reg[instr_word[24:20]];
        end
        if (commit && wr && (rd != 5'd0))
            rf_mem[rd] <= res_val;
        if ((state_reg == S_MOD) && mod_done)
        begin
            ba_reg   <= mod_rem;
            byte_reg <= 2'd0;
            ld_reg   <= 32'd0;
        end
        else if (state_reg == S_MRDW)
        begin
            ba_reg   <= ba_next;
            byte_reg <= byte_reg + 2'd1;
            ld_reg   <= ld_next;
        end
        if (state_reg == S_FIN)
        begin
            st_reg     <= fin_status;
            pc_out_reg <= commit ? npc : pc_reg;
            dr_reg     <= (commit && wr) ? rd : 5'd0;
            dw_reg     <= commit && wr && (rd != 5'd0);
            dv_reg     <= (commit && wr && (rd != 5'd0)) ? res_val : 32'd0;
        end
    end

    assign done         = done_reg;
    assign pc_after     = pc_out_reg;
    assign dest_reg     = dr_reg;
    assign dest_value   = dv_reg;
    assign dest_written = dw_reg;
    assign status       = st_reg;

    `RVX_ASSERT_IMP(a_done_idle, done, !busy, "result beat while busy")
    `RVX_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `RVX_ASSERT_IMP(a_no_x0_write, done && dest_written, dest_reg != 5'd0, "write to x0 flagged")
    `RVX_ASSERT_IMP(a_fail_pc_hold, done && (status != ST_OK), pc_after == pc_reg,
        "pc moved on a failed instruction")

endmodule

/* design/rvx_serial_alu.sv */
// Bit-serial ALU: operand lane, pc+imm lane, pc+4 lane and a one-place shifter.
module rvx_serial_alu import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_ctrl_t   ctrl,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    input  logic [31:0] opp,
    input  logic [31:0] opc,
    output alu_res_t    res,
    output logic        done
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SER   = 2'd1;
    localparam logic [1:0] PH_SHIFT = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [31:0] a_reg, b_reg, p_reg, c_reg, rx_reg, ry_reg, rz_reg;
    logic        cx_reg, cy_reg, cz_reg, ne_reg, a_msb_reg, b_msb_reg;
    logic [2:0]  op_reg;
    logic        sh_en_reg, left_reg, arith_reg;
    logic [4:0]  shamt_reg;

    logic        bx, sx, cxn, bitx, zb, sy, cyn, sz, czn;
    logic [31:0] ash_next;

    always_comb
    begin
        bx  = b_reg[0] ^ (op_reg == ALU_SUB);
        sx  = a_reg[0] ^ bx ^ cx_reg;
        cxn = (a_reg[0] & bx) | (a_reg[0] & cx_reg) | (bx & cx_reg);
        case (op_reg)
            ALU_XOR: bitx = a_reg[0] ^ b_reg[0];
            ALU_OR:  bitx = a_reg[0] | b_reg[0];
            ALU_AND: bitx = a_reg[0] & b_reg[0];
            default: bitx = sx;
        endcase
        sy  = p_reg[0] ^ c_reg[0] ^ cy_reg;
        cyn = (p_reg[0] & c_reg[0]) | (p_reg[0] & cy_reg) | (c_reg[0] & cy_reg);
        zb  = (cnt_reg == 5'd2);
        sz  = p_reg[0] ^ zb ^ cz_reg;
        czn = (p_reg[0] & zb) | (p_reg[0] & cz_reg) | (zb & cz_reg);
        ash_next = left_reg ? {a_reg[30:0], 1'b0} : {arith_reg & a_reg[31], a_reg[31:1]};
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_SER:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (sh_en_reg && (shamt_reg != 5'd0))
                    begin
                        phase_next = PH_SHIFT;
                        cnt_next   = shamt_reg;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            PH_SHIFT:
            begin
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                if (ctrl.load)
                begin
                    phase_next = PH_SER;
                    cnt_next   = 5'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && (phase_reg == PH_IDLE))
        begin
            a_reg     <= opa;
            b_reg     <= opb;
            p_reg     <= opp;
            c_reg     <= opc;
            op_reg    <= ctrl.op;
            cx_reg    <= (ctrl.op == ALU_SUB);
            cy_reg    <= 1'b0;
            cz_reg    <= 1'b0;
            ne_reg    <= 1'b0;
            a_msb_reg <= opa[31];
            b_msb_reg <= opb[31];
            sh_en_reg <= ctrl.shift_en;
            left_reg  <= ctrl.shift_left;
            arith_reg <= ctrl.shift_arith;
            shamt_reg <= ctrl.shamt;
        end
        else if (phase_reg == PH_SER)
        begin
            a_reg  <= {a_reg[0], a_reg[31:1]};
            b_reg  <= {b_reg[0], b_reg[31:1]};
            p_reg  <= {p_reg[0], p_reg[31:1]};
            c_reg  <= {1'b0, c_reg[31:1]};
            rx_reg <= {bitx, rx_reg[31:1]};
            ry_reg <= {sy, ry_reg[31:1]};
            rz_reg <= {sz, rz_reg[31:1]};
            cx_reg <= cxn;
            cy_reg <= cyn;
            cz_reg <= czn;
            ne_reg <= ne_reg | (a_reg[0] ^ b_reg[0]);
        end
        else if (phase_reg == PH_SHIFT)
        begin
            a_reg <= ash_next;
        end
    end

    assign res.rx    = rx_reg;
    assign res.ry    = ry_reg;
    assign res.rz    = rz_reg;
    assign res.ash   = a_reg;
    assign res.carry = cx_reg;
    assign res.ne    = ne_reg;
    assign res.a_msb = a_msb_reg;
    assign res.b_msb = b_msb_reg;
    assign done      = done_reg;

endmodule

/* design/rvx_mod_unit.sv */
// Bit-serial remainder by the memory size in bytes or in words.
module rvx_mod_unit
#(
    parameter int DATA_MEM_WORDS = 16384,
    localparam int BW = $clog2(DATA_MEM_WORDS * 4)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          sel_words,
    input  logic [31:0]   value,
    output logic [BW-1:0] rem,
    output logic          done
);

    localparam logic [BW:0] MB_C = (BW+1)'(DATA_MEM_WORDS * 4);
    localparam logic [BW:0] MW_C = (BW+1)'(DATA_MEM_WORDS);

    logic          run_reg, done_reg;
    logic [4:0]    cnt_reg;
    logic [31:0]   val_reg;
    logic [BW-1:0] r_reg, r_next;
    logic          sel_reg;
    logic [BW:0]   t, m;

    always_comb
    begin
        t = {r_reg, val_reg[31]};
        m = sel_reg ? MW_C : MB_C;
        r_next = (t >= m) ? BW'(t - m) : t[BW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            sel_reg <= sel_words;
            r_reg   <= '0;
        end
        else if (run_reg)
        begin
            val_reg <= {val_reg[30:0], 1'b0};
            r_reg   <= r_next;
        end
    end

    assign rem  = r_reg;
    assign done = done_reg;

endmodule

/* design/rvx_data_mem.sv */
// Single-port data memory with registered read.
module rvx_data_mem
#(
    parameter int DATA_MEM_WORDS = 16384,
    localparam int AW = $clog2(DATA_MEM_WORDS)
)
(
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DATA_MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

/* tb/rv32i_instruction_execute_checker.sv */
// Result checker for the RV32I execute block: predicts each beat and compares outputs.
`timescale 1ns / 100ps
module rv32i_instruction_execute_checker import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        req_type,
    input  logic [31:0] instr_word,
    input  logic [13:0] preload_index,
    input  logic [31:0] preload_word,
    input  logic        done,
    input  logic [31:0] pc_after,
    input  logic [4:0]  dest_reg,
    input  logic [31:0] dest_value,
    input  logic        dest_written,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    localparam int MEM_WORDS = 16384;

    typedef struct packed {
        logic [31:0] pc;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        wr;
        logic [1:0]  st;
    } exec_result_t;

    exec_result_t expected_q[$];
    logic [31:0] cur_pc;
    logic [31:0] regs [32];
    logic [31:0] dmem [MEM_WORDS];

    function automatic logic [7:0] rd_byte(input logic [31:0] a);
        logic [31:0] x;
        x = a % (MEM_WORDS * 4);
        return 8'(dmem[x >> 2] >> (8 * x[1:0]));
    endfunction

    function automatic logic [31:0] rd_bytes(input logic [31:0] a, input int n);
        logic [31:0] v;
        v = 0;
        for (int i = 0; i < n; i++)
            v |= 32'(rd_byte(a + i)) << (8 * i);
        return v;
    endfunction

    task automatic wr_bytes(input logic [31:0] a, input logic [31:0] v, input int n);
        logic [31:0] x;
        for (int i = 0; i < n; i++)
        begin
            x = (a + i) % (MEM_WORDS * 4);
            dmem[x >> 2][8 * x[1:0] +: 8] = v[8 * i +: 8];
        end
    endtask

    function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] s);
        return $signed(x) >>> s;
    endfunction

    task automatic execute_beat(input logic rq, input logic [31:0] w, input logic [13:0] pi,
                                input logic [31:0] pw, output exec_result_t r);
        logic [6:0] op, f7;
        logic [4:0] rd;
        logic [2:0] f3;
        logic [31:0] a, b, imm, res, npc, addr, lv;
        logic [1:0] st;
        logic wr, take;
        r = '0;
        r.pc = cur_pc;
        if (rq)
        begin
            dmem[pi % MEM_WORDS] = pw;
            return;
        end
        if (w == 0)
        begin
            r.st = ST_HALT;
            return;
        end
        op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
        a = regs[w[19:15]]; b = regs[w[24:20]];
        npc = cur_pc + 4; st = ST_OK; wr = 0; res = 0;
        imm = {{20{w[31]}}, w[31:20]};
        case (op)
            OPC_OP:
            begin
                wr = 1;
                if (f7 == F7_ALT && f3 == F3_ADD) res = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR) res = sra(a, b[4:0]);
                else if (f7 != F7_BASE) st = ST_UNSUP;
                else case (f3)
                    F3_ADD:  res = a + b;
                    F3_SLL:  res = a << b[4:0];
                    F3_SLT:  res = 32'($signed(a) < $signed(b));
                    F3_SLTU: res = 32'(a < b);
                    F3_XOR:  res = a ^ b;
                    F3_SR:   res = a >> b[4:0];
                    F3_OR:   res = a | b;
                    default: res = a & b;
                endcase
            end
            OPC_OPIMM:
            begin
                wr = 1;
                case (f3)
                    F3_ADD:  res = a + imm;
                    F3_SLT:  res = 32'($signed(a) < $signed(imm));
                    F3_SLTU: res = 32'(a < imm);
                    F3_XOR:  res = a ^ imm;
                    F3_OR:   res = a | imm;
                    F3_AND:  res = a & imm;
                    F3_SLL:
                    begin
                        if (f7 != F7_BASE) st = ST_UNSUP;
                        res = a << w[24:20];
                    end
                    default:
                        if (f7 == F7_ALT) res = sra(a, w[24:20]);
                        else if (f7 == F7_BASE) res = a >> w[24:20];
                        else st = ST_UNSUP;
                endcase
            end
            OPC_LOAD:
            begin
                wr = 1;
                addr = a + imm;
                case (f3)
                    F3_LB:
                    begin
                        lv = rd_bytes(addr, 1);
                        res = {{24{lv[7]}}, lv[7:0]};
                    end
                    F3_LH:
                    begin
                        lv = rd_bytes(addr, 2);
                        res = {{16{lv[15]}}, lv[15:0]};
                    end
                    F3_LW:  res = rd_bytes(addr, 4);
                    F3_LBU: res = rd_bytes(addr, 1);
                    F3_LHU: res = rd_bytes(addr, 2);
                    default: st = ST_UNSUP;
                endcase
            end
            OPC_STORE:
                if (f3 > F3_SW) st = ST_UNSUP;
                else
                begin
                    addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
                    wr_bytes(addr, b, f3 == F3_SB ? 1 : (f3 == F3_SH ? 2 : 4));
                end
            OPC_LUI:
            begin
                res = {w[31:12], 12'b0}; wr = 1;
            end
            OPC_AUIPC:
            begin
                res = cur_pc + {w[31:12], 12'b0}; wr = 1;
            end
            OPC_JAL:
            begin
                npc = cur_pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                if (npc[1:0] != 0) st = ST_MISAL;
                res = cur_pc + 4; wr = 1;
            end
            OPC_JALR:
                if (f3 != 0) st = ST_UNSUP;
                else
                begin
                    npc = (a + imm) & ~32'd1;
                    if (npc[1:0] != 0) st = ST_MISAL;
                    res = cur_pc + 4; wr = 1;
                end
            OPC_BRANCH:
            begin
                case (f3)
                    F3_BEQ:  take = a == b;
                    F3_BNE:  take = a != b;
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = $signed(a) >= $signed(b);
                    F3_BLTU: take = a < b;
                    F3_BGEU: take = a >= b;
                    default:
                    begin
                        take = 0; st = ST_UNSUP;
                    end
                endcase
                if (take)
                begin
                    npc = cur_pc + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    if (npc[1:0] != 0) st = ST_MISAL;
                end
            end
            default: st = ST_UNSUP;
        endcase
        if (st != ST_OK)
        begin
            r.st = st;
            return;
        end
        cur_pc = npc;
        r.pc = npc;
        if (wr)
        begin
            r.rd = rd;
            if (rd != 0)
            begin
                regs[rd] = res;
                r.val = res;
                r.wr = 1;
            end
        end
    endtask

    initial
    begin
        cur_pc = 0;
        foreach (regs[i]) regs[i] = 0;
        regs[2] = 32'd65536;
        foreach (dmem[i]) dmem[i] = 0;
        fail_count = 0;
        result_count = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n && done)
        begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result pc=%h rd=%0d val=%h wr=%b st=%0d", $time,
                         pc_after, dest_reg, dest_value, dest_written, status);
                fail_count <= fail_count + 1;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e != {pc_after, dest_reg, dest_value, dest_written, status})
                begin
                    $display("%0t: mismatch expected pc=%h rd=%0d val=%h wr=%b st=%0d", $time,
                             e.pc, e.rd, e.val, e.wr, e.st);
                    $display("%0t:          actual pc=%h rd=%0d val=%h wr=%b st=%0d", $time,
                             pc_after, dest_reg, dest_value, dest_written, status);
                    fail_count <= fail_count + 1;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            execute_beat(req_type, instr_word, preload_index, preload_word, e);
            expected_q.push_back(e);
        end
    end
endmodule

/* tb/rv32i_instruction_execute_tb.sv */
// Testbench top for the RV32I execute block: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module rv32i_instruction_execute_tb import rvx_pkg::*;
();
    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done, dest_written;
    logic req_type = 0;
    logic [31:0] instr_word = 0;
    logic [13:0] preload_index = 0;
    logic [31:0] preload_word = 0;
    logic [31:0] pc_after, dest_value;
    logic [4:0] dest_reg;
    logic [1:0] status;
    int fail_count, pending, result_count;
    int idle_pct;
    int beats;
    int quiet;

    always #4 clk = ~clk;

    rv32i_instruction_execute uut (.*);
    rv32i_instruction_execute_checker chk (.*);

    // watchdog: covers the post-reset memory clear and the slowest beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 100000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [4:0] rreg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [6:0] op;
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 13))
            0, 1:  op = OPC_OP;
            2, 3:  op = OPC_OPIMM;
            4, 5:  op = OPC_LOAD;
            6, 7:  op = OPC_STORE;
            8:     op = OPC_LUI;
            9:     op = OPC_AUIPC;
            10:    op = OPC_JAL;
            11:    op = OPC_JALR;
            12:    op = OPC_BRANCH;
            default: return ($urandom_range(0, 3) == 0) ? 32'd0 : w;
        endcase
        w[6:0] = op;
        w[11:7] = rreg();
        w[19:15] = rreg();
        w[24:20] = rreg();
        if ((op == OPC_OP || op == OPC_OPIMM) && $urandom_range(0, 7) != 0)
            w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        if ((op == OPC_LOAD || op == OPC_STORE) && $urandom_range(0, 3) != 0)
            w[31:25] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
        if ((op == OPC_JAL || op == OPC_BRANCH) && $urandom_range(0, 3) != 0)
            w[8] = 0;
        if (op == OPC_JALR && $urandom_range(0, 3) != 0) w[14:12] = 0;
        return w;
    endfunction

    // the block stays busy through each beat, so the extra edge costs nothing
    task automatic send(input logic rq, input logic [31:0] w, input logic [13:0] pi,
                        input logic [31:0] pw);
        @(posedge clk);
        while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
        start <= 1;
        req_type <= rq;
        instr_word <= w;
        preload_index <= pi;
        preload_word <= pw;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 0;
        beats++;
    endtask

    initial
    begin
        idle_pct = 0;
        beats = 0;
        quiet = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed beats
        send(1, 0, 0, 32'h8081_82FF);
        send(1, 0, 14'h3FFF, 32'hFFFF_FFFF);
        send(0, 32'h0000_0000, 0, 0);
        send(0, 32'hFFFF_FFFF, 0, 0);
        send(0, 32'h8000_00B7, 0, 0);              // lui x1
        send(0, 32'h7FF0_8093, 0, 0);              // addi x1,x1,2047
        send(0, 32'h4010_D193, 0, 0);              // srai x3,x1,1
        send(0, 32'h4020_8233, 0, 0);              // sub x4,x1,x2
        send(0, 32'h0020_A2B3, 0, 0);              // slt x5,x1,x2
        send(0, 32'h0000_0303, 0, 0);              // lb x6,0(x0)
        send(0, 32'h0000_4383, 0, 0);              // lbu x7,0(x0)
        send(0, 32'hFFF0_1403, 0, 0);              // lh x8,-1(x0) wraps
        send(0, 32'h0030_2023, 0, 0);              // sw x3,0(x0)
        send(0, 32'h0000_0517, 0, 0);              // auipc
        send(0, 32'h0080_05EF, 0, 0);              // jal x11,8
        send(0, 32'h0020_006F, 0, 0);              // jal misaligned
        send(0, 32'h0011_0667, 0, 0);              // jalr x12,1(x2)
        send(0, 32'h0000_0463, 0, 0);              // beq taken
        send(0, 32'h0000_1463, 0, 0);              // bne not taken
        send(0, 32'h0000_0163, 0, 0);              // beq misaligned
        send(0, 32'h0000_2063, 0, 0);              // bad branch funct3
        send(0, 32'h0000_3003, 0, 0);              // bad load funct3
        send(0, 32'h0000_3023, 0, 0);              // bad store funct3
        send(0, 32'h0000_000F, 0, 0);              // fence
        while (pending != 0) @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 67 : (ph == 3 ? 16 : 0);
            for (int i = 0; i < 355; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(1, 0, ($urandom_range(0, 1) ? 14'($urandom) : 14'($urandom_range(0, 7))),
                         $urandom);
                else
                    send(0, rand_instr(), 0, 0);
            end
            while (pending != 0) @(posedge clk);
        end
        repeat (100) @(posedge clk);
        $display("Ran %0d beats (ALU, loads, stores, jumps, branches, preloads, bad encodings)",
                 beats);
        $display("with idle ratios of 0, 67 and 16 percent; %0d results checked", result_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
